// File: rtl/core/meb_pkg.sv
// Shared types and constants for the MIDI event byte encoder.
`default_nettype none

package meb_pkg;

    // Event kinds carried in the low bits of s_tuser.
    localparam logic [2:0] OP_CHANNEL  = 3'd0;
    localparam logic [2:0] OP_TEMPO    = 3'd1;
    localparam logic [2:0] OP_TIME_SIG = 3'd2;
    localparam logic [2:0] OP_KEY_SIG  = 3'd3;
    localparam logic [2:0] OP_END      = 3'd4;
    localparam logic [2:0] OP_SET_TIME = 3'd5;

    localparam logic [7:0] META_STATUS   = 8'hFF;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [7:0] META_TIME_SIG = 8'h58;
    localparam logic [7:0] META_KEY_SIG  = 8'h59;
    localparam logic [7:0] META_END      = 8'h2F;
    localparam logic [7:0] CLOCKS_32ND   = 8'h08;
    localparam logic [9:0] CLOCKS_BASE   = 10'd960;

    localparam int unsigned MAX_BYTES = 11;
    localparam int unsigned VLQ_BYTES = 4;
    localparam int unsigned BODY_BYTES = 7;

    // One encoded event: its bytes in output order and the index of the final one.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [3:0]                last_idx;
    } meb_job_t;

endpackage

`default_nettype wire

// File: rtl/core/meb_front.sv
// Front end: accepts events, tracks running status and pending time, builds byte lists.
`default_nettype none

module meb_front
    import meb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic [3:0]  s_tuser,
    input  wire logic        q_full,
    output logic             q_push,
    output meb_job_t         q_job
);

    logic [7:0]  running_status_reg, running_status_next;
    logic [27:0] pending_time_reg, pending_time_next;

    logic [2:0]  opcode;
    logic        time_given;
    logic [27:0] delta_time;
    logic [7:0]  status_byte;
    logic [6:0]  data_one, data_two;
    logic [23:0] tempo_us;
    logic [7:0]  sig_numerator;
    logic [2:0]  sig_denominator_log2;
    logic [3:0]  key_sharps;

    logic                      accept;
    logic [27:0]               delta;
    logic [2:0]                vlq_cnt;
    logic [VLQ_BYTES-1:0][6:0] groups;
    logic [VLQ_BYTES-1:0][7:0] vlq;
    logic [BODY_BYTES-1:0][7:0] body;
    logic [2:0]                body_cnt;
    logic [7:0]                chan_status;
    logic [6:0]                chan_d2;
    logic                      send_status;
    logic                      two_byte_msg;
    logic [1:0]                grp;
    logic [3:0]                sel;

    assign opcode               = s_tuser[2:0];
    assign time_given           = s_tuser[3];
    assign delta_time           = s_tdata[27:0];
    assign status_byte          = s_tdata[35:28];
    assign data_one             = s_tdata[42:36];
    assign data_two             = s_tdata[49:43];
    assign tempo_us             = s_tdata[73:50];
    assign sig_numerator        = s_tdata[81:74];
    assign sig_denominator_log2 = s_tdata[84:82];
    assign key_sharps           = s_tdata[88:85];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign delta    = time_given ? delta_time : pending_time_reg;

    // Note-off becomes note-on with velocity zero.
    always_comb begin
        chan_status = status_byte;
        chan_d2     = data_two;
        if (status_byte[7:4] == 4'h8) begin
            chan_status = {4'h9, status_byte[3:0]};
            chan_d2     = 7'd0;
        end
        send_status  = (chan_status != running_status_reg) || (chan_status < 8'h80)
                       || (chan_status > 8'hDF);
        two_byte_msg = (chan_status >= 8'hC0) && (chan_status <= 8'hDF);
    end

    // Variable-length quantity, most significant group first.
    always_comb begin
        for (int g = 0; g < VLQ_BYTES; g++) begin
            groups[g] = delta[7*g +: 7];
        end
        if (delta[27:21] != '0) begin
            vlq_cnt = 3'd4;
        end else if (delta[20:14] != '0) begin
            vlq_cnt = 3'd3;
        end else if (delta[13:7] != '0) begin
            vlq_cnt = 3'd2;
        end else begin
            vlq_cnt = 3'd1;
        end
        for (int i = 0; i < VLQ_BYTES; i++) begin
            grp    = 2'(vlq_cnt - 3'd1 - 3'(i));
            vlq[i] = {(grp != 2'd0), groups[grp]};
        end
    end

    always_comb begin
        body     = '0;
        body_cnt = 3'd1;
        unique case (opcode)
            OP_CHANNEL: begin
                if (send_status) begin
                    body[0]  = chan_status;
                    body[1]  = {1'b0, data_one};
                    body[2]  = {1'b0, chan_d2};
                    body_cnt = two_byte_msg ? 3'd2 : 3'd3;
                end else begin
                    body[0]  = {1'b0, data_one};
                    body[1]  = {1'b0, chan_d2};
                    body_cnt = two_byte_msg ? 3'd1 : 3'd2;
                end
            end
            OP_TEMPO: begin
                body[0]  = META_STATUS;
                body[1]  = META_TEMPO;
                body[2]  = 8'h03;
                body[3]  = tempo_us[23:16];
                body[4]  = tempo_us[15:8];
                body[5]  = tempo_us[7:0];
                body_cnt = 3'd6;
            end
            OP_TIME_SIG: begin
                body[0]  = META_STATUS;
                body[1]  = META_TIME_SIG;
                body[2]  = 8'h04;
                body[3]  = sig_numerator;
                body[4]  = {5'd0, sig_denominator_log2};
                body[5]  = 8'(CLOCKS_BASE >> sig_denominator_log2);
                body[6]  = CLOCKS_32ND;
                body_cnt = 3'd7;
            end
            OP_KEY_SIG: begin
                body[0]  = META_STATUS;
                body[1]  = META_KEY_SIG;
                body[2]  = 8'h02;
                body[3]  = {{4{key_sharps[3]}}, key_sharps};
                body[4]  = 8'h00;
                body_cnt = 3'd5;
            end
            default: begin
                body[0]  = META_STATUS;
                body[1]  = META_END;
                body[2]  = 8'h00;
                body_cnt = 3'd3;
            end
        endcase
    end

    // Splice the body after the delta bytes.
    always_comb begin
        q_job = '0;
        for (int j = 0; j < MAX_BYTES; j++) begin
            sel = 4'(j) - {1'b0, vlq_cnt};
            if (4'(j) < {1'b0, vlq_cnt}) begin
                q_job.bytes[j] = vlq[2'(j)];
            end else if (sel < 4'(BODY_BYTES)) begin
                q_job.bytes[j] = body[sel[2:0]];
            end
        end
        q_job.last_idx = {1'b0, vlq_cnt} + {1'b0, body_cnt} - 4'd1;
        q_push         = accept && (opcode <= OP_END);
    end

    always_comb begin
        running_status_next = running_status_reg;
        pending_time_next   = pending_time_reg;
        if (accept) begin
            if (opcode == OP_SET_TIME) begin
                pending_time_next = delta_time;
            end else if (opcode == OP_CHANNEL) begin
                pending_time_next   = '0;
                running_status_next = chan_status;
            end else if (opcode <= OP_END) begin
                pending_time_next   = '0;
                running_status_next = META_STATUS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_status_reg <= '0;
            pending_time_reg   <= '0;
        end else begin
            running_status_reg <= running_status_next;
            pending_time_reg   <= pending_time_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/meb_fifo.sv
// Short queue of encoded events between the front end and the byte sender.
`default_nettype none

module meb_fifo
    import meb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire meb_job_t push_job,
    input  wire logic     pop,
    output logic          full,
    output logic          not_empty,
    output meb_job_t      head_job
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    meb_job_t               mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/meb_back.sv
// Back end: sends the bytes of queued events one per cycle while m_tready is high, through an output register.
`default_nettype none

module meb_back
    import meb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_not_empty,
    input  wire meb_job_t    q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic [3:0] idx_reg, idx_next;
    logic       load;
    logic       at_last;

    assign load    = q_not_empty && (!out_valid_reg || m_tready);
    assign at_last = (idx_reg == q_head.last_idx);
    assign q_pop   = load && at_last;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        idx_next       = idx_reg;
        if (load) begin
            out_valid_next = 1'b1;
            out_byte_next  = q_head.bytes[idx_reg];
            out_last_next  = at_last;
            idx_next       = at_last ? 4'd0 : idx_reg + 4'd1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/midi_event_byte_encoder.sv
// Top level of the MIDI track event to file byte encoder.
`default_nettype none

// Each accepted event is turned into its standard MIDI file track bytes: the
// delta time as a variable-length quantity (one to four bytes) followed by the
// channel message or meta event, with m_tlast on the final byte. The output
// delivers one byte per cycle while m_tready is high, and an event is two to
// eleven bytes long, set by the length of its delta and of its message. A
// two-entry event queue lets the input accept events on consecutive cycles
// until two encoded events wait for the output; after that the input takes one
// event each time the output finishes one. Set-time events (kind 5) only load
// the held delta and produce no bytes; kinds 6 and 7 are ignored.
module midi_event_byte_encoder
    import meb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // delta_time, status_byte, data_one, data_two, tempo_us, sig_numerator,
    // sig_denominator_log2, key_sharps, zero pad
    input  wire logic [95:0] s_tdata,
    // opcode, time_given
    input  wire logic [3:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_byte
    output logic [7:0]       m_tdata,
    // last_byte
    output logic             m_tlast
);

    logic     q_push, q_pop, q_full, q_not_empty;
    meb_job_t q_job, q_head;

    meb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    meb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (q_head)
    );

    meb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the MIDI track event byte encoder.
`default_nettype none

module tb;
    import meb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kinds 6 and 7 carry no meaning and must leave the encoder untouched.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RANDOM_EVENTS = 150;

    typedef struct packed {
        logic [2:0]  op;
        logic        given;
        logic [27:0] delta;
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [23:0] tempo;
        logic [7:0]  num;
        logic [2:0]  den;
        logic [3:0]  key;
        logic [3:0]  nexp;
        logic [87:0] exp_bytes;
    } track_event_t;

    typedef struct packed {
        logic [3:0]       n;
        logic [10:0][7:0] b;
    } event_bytes_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } track_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    track_byte_t  bytes_due[$];
    track_event_t cur_event;
    logic [7:0]   run_status;
    logic [27:0]  held_delta;
    logic [7:0]   last_status;
    int unsigned  errors = 0;
    int unsigned  idle_cycles = 0;
    bit           no_idle;

    midi_event_byte_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic track_event_t ev(logic [2:0] op, logic given, logic [27:0] delta,
                                        logic [7:0] status, logic [6:0] d1, logic [6:0] d2,
                                        logic [23:0] tempo, logic [7:0] num, logic [2:0] den,
                                        logic [3:0] key);
        track_event_t r;
        r = '0;
        r.op = op;
        r.given = given;
        r.delta = delta;
        r.status = status;
        r.d1 = d1;
        r.d2 = d2;
        r.tempo = tempo;
        r.num = num;
        r.den = den;
        r.key = key;
        return r;
    endfunction

    // Attaches hand-written bytes, first byte in the most significant position.
    function automatic track_event_t with_bytes(track_event_t r, int n, logic [87:0] v);
        r.nexp = 4'(n);
        r.exp_bytes = v;
        return r;
    endfunction

    // Computes the file bytes of one event and advances the encoder state.
    function automatic event_bytes_t encode_event(track_event_t r);
        event_bytes_t e;
        logic [7:0]   bq[$];
        logic [27:0]  t;
        logic [7:0]   s;
        logic [6:0]   d2;
        logic [9:0]   clocks;
        int           k;
        int           i;
        e = '0;
        if (r.op == OP_SET_TIME) begin
            held_delta = r.delta;
            return e;
        end
        if (r.op > OP_SET_TIME) return e;
        t = r.given ? r.delta : held_delta;
        held_delta = '0;
        k = 1;
        while (k < 4 && (t >> (7 * k)) != 0) k++;
        for (i = k - 1; i >= 0; i--) begin
            bq.push_back({(i != 0), t[7 * i +: 7]});
        end
        if (r.op == OP_CHANNEL) begin
            s = r.status;
            d2 = r.d2;
            // Note-off is written as note-on with zero velocity.
            if (s >= 8'h80 && s <= 8'h8F) begin
                s = s + 8'h10;
                d2 = '0;
            end
            if (s != run_status || s < 8'h80 || s > 8'hDF) bq.push_back(s);
            run_status = s;
            bq.push_back({1'b0, r.d1});
            if (!(s >= 8'hC0 && s <= 8'hDF)) bq.push_back({1'b0, d2});
        end else begin
            bq.push_back(META_STATUS);
            run_status = META_STATUS;
            case (r.op)
                OP_TEMPO: begin
                    bq.push_back(META_TEMPO);
                    bq.push_back(8'h03);
                    bq.push_back(r.tempo[23:16]);
                    bq.push_back(r.tempo[15:8]);
                    bq.push_back(r.tempo[7:0]);
                end
                OP_TIME_SIG: begin
                    clocks = CLOCKS_BASE >> r.den;
                    bq.push_back(META_TIME_SIG);
                    bq.push_back(8'h04);
                    bq.push_back(r.num);
                    bq.push_back({5'd0, r.den});
                    bq.push_back(clocks[7:0]);
                    bq.push_back(CLOCKS_32ND);
                end
                OP_KEY_SIG: begin
                    bq.push_back(META_KEY_SIG);
                    bq.push_back(8'h02);
                    bq.push_back({{4{r.key[3]}}, r.key});
                    bq.push_back(8'h00);
                end
                default: begin
                    bq.push_back(META_END);
                    bq.push_back(8'h00);
                end
            endcase
        end
        e.n = 4'(bq.size());
        for (i = 0; i < bq.size(); i++) e.b[i] = bq[i];
        return e;
    endfunction

    function automatic track_event_t random_event();
        track_event_t r;
        int           pick;
        r = '0;
        pick = $urandom_range(0, 99);
        if (pick < 50) r.op = OP_CHANNEL;
        else if (pick < 59) r.op = OP_TEMPO;
        else if (pick < 68) r.op = OP_TIME_SIG;
        else if (pick < 77) r.op = OP_KEY_SIG;
        else if (pick < 84) r.op = OP_END;
        else if (pick < 97) r.op = OP_SET_TIME;
        else r.op = pick[0] ? OP_UNUSED_7 : OP_UNUSED_6;
        r.given = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0: r.delta = '0;
            1: r.delta = 28'($urandom_range(1, 127));
            2: r.delta = 28'($urandom_range(128, 16383));
            3: r.delta = 28'($urandom_range(16384, 2097151));
            default: r.delta = 28'($urandom);
        endcase
        pick = $urandom_range(0, 9);
        // Repeating the previous status keeps running status in play.
        if (pick < 4) r.status = last_status;
        else if (pick < 9) r.status = 8'($urandom_range(128, 239));
        else r.status = 8'($urandom_range(0, 255));
        last_status = r.status;
        r.d1 = 7'($urandom);
        r.d2 = 7'($urandom);
        r.tempo = 24'($urandom);
        r.num = 8'($urandom);
        r.den = 3'($urandom_range(0, 7));
        r.key = 4'($urandom);
        return r;
    endfunction

    task automatic send_event(track_event_t r);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        cur_event = r;
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, r.key, r.den, r.num, r.tempo, r.d2, r.d1, r.status, r.delta};
        s_tuser <= {r.given, r.op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (bytes_due.size() != 0);
    endtask

    // Result receiver with random stall bursts.
    int unsigned stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Records the expected bytes of each accepted event and checks each result transaction.
    always @(posedge aclk) begin
        event_bytes_t e;
        track_byte_t  got;
        track_byte_t  want;
        int           i;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                e = encode_event(cur_event);
                if (cur_event.nexp != 0) begin
                    for (i = 0; i < cur_event.nexp; i++) begin
                        bytes_due.push_back({cur_event.exp_bytes[(cur_event.nexp - 1 - i) * 8 +: 8],
                                             (i == cur_event.nexp - 1)});
                    end
                end else begin
                    for (i = 0; i < e.n; i++) bytes_due.push_back({e.b[i], (i == e.n - 1)});
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tlast};
                if (bytes_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transaction, expected none, got %02h last %0b",
                             $time, got.value, got.last);
                end else begin
                    want = bytes_due.pop_front();
                    if (got.value !== want.value || got.last !== want.last) begin
                        errors++;
                        $display("%0t: mismatch, expected %02h last %0b, got %02h last %0b",
                                 $time, want.value, want.last, got.value, got.last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        track_event_t dir_rows[$];
        track_event_t r;
        int           count;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        no_idle = 1'b0;
        run_status = '0;
        held_delta = '0;
        last_status = 8'h90;
        cur_event = '0;

        dir_rows.push_back(with_bytes(ev(OP_END, 1, 28'd0, 8'h00, 0, 0, 0, 0, 0, 0),
                                      4, {8'h00, 8'hFF, 8'h2F, 8'h00}));
        dir_rows.push_back(with_bytes(ev(OP_CHANNEL, 1, 28'h7F, 8'h90, 7'h7F, 7'h7F, 0, 0, 0, 0),
                                      4, {8'h7F, 8'h90, 8'h7F, 8'h7F}));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'h80, 8'h90, 7'h3C, 7'h40, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'h3FFF, 8'h85, 7'h3C, 7'h55, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'h4000, 8'h8F, 7'h00, 7'h7F, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'h1FFFFF, 8'h9F, 7'h01, 7'h02, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'h200000, 8'hC3, 7'h05, 7'h7F, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'd1, 8'hC3, 7'h06, 7'h7F, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'd2, 8'hDF, 7'h7F, 7'h11, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'd3, 8'hE0, 7'h12, 7'h34, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'd4, 8'hE0, 7'h12, 7'h34, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'd5, 8'h00, 7'h21, 7'h22, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_CHANNEL, 1, 28'd6, 8'hFF, 7'h23, 7'h24, 0, 0, 0, 0));
        dir_rows.push_back(with_bytes(ev(OP_TIME_SIG, 1, 28'hFFFFFFF, 0, 0, 0, 0, 8'hFF, 3'd0, 0),
                                      11, {8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h58, 8'h04,
                                           8'hFF, 8'h00, 8'hC0, 8'h08}));
        dir_rows.push_back(ev(OP_SET_TIME, 0, 28'hFFFFFFF, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(with_bytes(ev(OP_TEMPO, 0, 28'd0, 0, 0, 0, 24'hFFFFFF, 0, 0, 0),
                                      10, {8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h51, 8'h03,
                                           8'hFF, 8'hFF, 8'hFF}));
        dir_rows.push_back(ev(OP_CHANNEL, 0, 28'hABCDEF, 8'h90, 7'h40, 7'h40, 0, 0, 0, 0));
        dir_rows.push_back(with_bytes(ev(OP_KEY_SIG, 1, 28'd0, 0, 0, 0, 0, 0, 0, 4'h8),
                                      6, {8'h00, 8'hFF, 8'h59, 8'h02, 8'hF8, 8'h00}));
        dir_rows.push_back(ev(OP_KEY_SIG, 1, 28'd9, 0, 0, 0, 0, 0, 0, 4'h7));
        dir_rows.push_back(ev(OP_KEY_SIG, 1, 28'd10, 0, 0, 0, 0, 0, 0, 4'h9));
        dir_rows.push_back(ev(OP_TIME_SIG, 1, 28'd11, 0, 0, 0, 0, 8'h00, 3'd6, 0));
        dir_rows.push_back(ev(OP_TIME_SIG, 1, 28'd12, 0, 0, 0, 0, 8'h04, 3'd7, 0));
        dir_rows.push_back(ev(OP_UNUSED_6, 1, 28'd13, 8'h90, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_SET_TIME, 1, 28'd300, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_UNUSED_7, 1, 28'd14, 8'h90, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(ev(OP_END, 0, 28'd15, 0, 0, 0, 0, 0, 0, 0));

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_event(dir_rows[i]);

        count = 0;
        while (count < RANDOM_EVENTS) begin
            // The sender holds off at the halfway count so the encoder runs completely dry mid-run.
            if (count == RANDOM_EVENTS / 2) drain_results();
            if (count == RANDOM_EVENTS - 30) no_idle = 1'b1;
            r = random_event();
            send_event(r);
            if (r.op <= OP_SET_TIME) count++;
        end
        s_tvalid <= 1'b0;

        while (bytes_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
